### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Constants and helper functions for the signed integer to ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

	localparam int DATA_W     = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CNT_W      = $clog2(DATA_W);
	localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

	localparam logic [7:0] SYM_MINUS = 8'd45;
	localparam logic [7:0] SYM_ZERO  = 8'd48;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [BCD_W-1:0]  bcd_t;

	// Add 3 to every digit of 5 or more (one double-dabble correction)
	function automatic bcd_t bcd_adjust(input bcd_t d);
		bcd_t r;
		r = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (d[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = d[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	// True when every digit is a decimal digit
	function automatic logic bcd_ok(input bcd_t d);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (d[4*i +: 4] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

### rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value): one signed 32-bit request.
//   Output channel (out_valid/out_ready, char_code, is_last): the decimal
//   text, one character per transfer, most significant first. A '-' leads
//   negative numbers, leading zeros are dropped, zero gives a single '0'.
//   is_last marks the final character of each number.
// Timing:
//   One shift-and-correct unit turns the magnitude into ten BCD digits,
//   then leading zero digits are dropped, then the characters leave at one
//   per cycle while the receiver keeps up (1 to 11 of them). The next
//   request is taken the cycle after the last character is loaded.
//   in_ready is high only while the sequencer is idle.
// Reset and stalls:
//   arst_n clears the sequencer and the output valid; no data is held over.
//   A stalled receiver freezes the output register, and the sequencer waits once it is ready to emit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sitoa_pkg::data_t       value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             char_code,
	output logic                   is_last
);
	import sitoa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	localparam logic [CNT_W-1:0]  CONV_LAST = CNT_W'(DATA_W - 1);
	localparam logic [LEFT_W-1:0] ALL_DIGITS = LEFT_W'(NUM_DIGITS);
	localparam logic [LEFT_W-1:0] ONE_DIGIT  = LEFT_W'(1);

	state_t              state_q;
	data_t               mag_q;
	bcd_t                bcd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [LEFT_W-1:0]   left_q;
	logic                neg_q;
	logic                out_valid_q;
	logic [7:0]          char_code_q;
	logic                is_last_q;

	logic                in_fire;
	logic                out_fire;
	logic                out_free;
	logic                in_emit;
	logic                tail_busy;
	logic [3:0]          top_digit;
	bcd_t                bcd_adj;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign in_emit   = (state_q == ST_EMIT);
	assign tail_busy = (state_q == ST_SKIP) || (state_q == ST_EMIT);
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign bcd_adj   = bcd_adjust(bcd_q);

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign is_last   = is_last_q;

	// Sequencer, conversion datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			left_q      <= '0;
			neg_q       <= 1'b0;
		end else begin
			// drop the output once taken; in the emit state a new character refills it
			if (out_fire && !in_emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						neg_q   <= value[DATA_W-1];
						mag_q   <= value[DATA_W-1] ? (data_t'(0) - value) : value;
						bcd_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					// correct digits, then shift in the next magnitude bit
					bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[DATA_W-1]};
					mag_q <= {mag_q[DATA_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CONV_LAST) begin
						left_q  <= ALL_DIGITS;
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zero digits, keep at least one
					if (top_digit == 4'd0 && left_q != ONE_DIGIT) begin
						bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
						left_q <= left_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (neg_q) begin
							char_code_q <= SYM_MINUS;
							is_last_q   <= 1'b0;
							neg_q       <= 1'b0;
						end else begin
							char_code_q <= SYM_ZERO + {4'd0, top_digit};
							is_last_q   <= (left_q == ONE_DIGIT);
							bcd_q       <= {bcd_q[BCD_W-5:0], 4'd0};
							left_q      <= left_q - 1'b1;
							if (left_q == ONE_DIGIT) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	`ASSERT_IMPLY(a_bcd_legal, clk, arst_n, tail_busy, bcd_ok(bcd_q), "BCD digit out of range")
	`ASSERT_IMPLY(a_emit_left, clk, arst_n, in_emit, left_q != '0, "emit with no digits left")
	`ASSERT_NEXT(a_run_cont, clk, arst_n, out_fire && !is_last_q, out_valid_q || in_emit, "run broken")

endmodule

### test/sitoa_checker.sv
// ----------------------------------------------------------------------------
// sitoa_checker
// Watches both channels of the integer to ASCII converter, predicts the
// decimal text of every accepted request and compares each character that
// leaves the block against the oldest predicted one.
// ----------------------------------------------------------------------------
module sitoa_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  sitoa_pkg::data_t  value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        char_code,
	input  logic              is_last,
	output int                fail_count,
	output int                pending
);
	import sitoa_pkg::*;

	localparam logic [31:0] DECIMAL_BASE = 32'd10;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	// Characters still owed by the block, oldest first
	text_char_t char_queue [$];

	// Append the decimal text of one request to the queue
	function automatic void queue_decimal_text(input data_t v);
		logic [31:0] mag;
		logic [3:0]  digit_buf [NUM_DIGITS];
		int          n;
		mag = v[31] ? (32'd0 - v) : v;
		n = 0;
		// collect digits, least significant first
		do begin
			digit_buf[n] = 4'(mag % DECIMAL_BASE);
			mag = mag / DECIMAL_BASE;
			n++;
		end while (mag != 32'd0 && n < NUM_DIGITS);
		if (v[31]) begin
			char_queue.push_back(text_char_t'{code: SYM_MINUS, last: 1'b0});
		end
		for (int i = n - 1; i >= 0; i--) begin
			char_queue.push_back(text_char_t'{code: SYM_ZERO + 8'(digit_buf[i]),
				last: (i == 0)});
		end
	endfunction

	// Compare departing characters, then record new requests
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		int         errs;
		if (!arst_n) begin
			char_queue.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			if (out_valid && out_ready) begin
				if (char_queue.size() == 0) begin
					$error("unexpected character: char_code %0d is_last %0b",
						char_code, is_last);
					errs++;
				end else begin
					want = char_queue.pop_front();
					if (char_code !== want.code) begin
						$error("char_code: expected %0d, actual %0d", want.code, char_code);
						errs++;
					end
					if (is_last !== want.last) begin
						$error("is_last: expected %0b, actual %0b", want.last, is_last);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				queue_decimal_text(value);
			end
			pending    <= char_queue.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the integer to ASCII converter with corner values and then random
// numbers of every length and sign, under phases of sender gaps and
// receiver stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
	import sitoa_pkg::*;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	localparam int RANDOM_ITEMS = 128;
	localparam int DRAIN_CYCLES = 60;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	data_t      value;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] char_code;
	logic       is_last;
	int         fail_count;
	int         pending;
	idle_mode_t idle_mode;

	// Zero, one digit, ten digits, both extremes, alternating bit patterns
	data_t corner_values [$] = '{
		32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h00000009, 32'hFFFFFFF7,
		32'h0000000A, 32'hFFFFFFF6, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
		32'h7FFFFFFE, 32'h3B9ACA00, 32'hC4653600, 32'h3B9AC9FF, 32'h55555555,
		32'hAAAAAAAA, 32'h00000064, 32'h00003039, 32'hFFFFCFC7, 32'h000F4240,
		32'h000186A0
	};

	signed_int_to_decimal_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.is_last   (is_last)
	);

	sitoa_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_code  (char_code),
		.is_last    (is_last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the receiver according to the current phase
	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: begin
				out_ready <= ($urandom_range(99) >= 46);
			end
			IDLE_BOTH: begin
				out_ready <= ($urandom_range(99) >= 10);
			end
			default: begin
				out_ready <= 1'b1;
			end
		endcase
	end

	// Offer one request, with an optional gap first, and hold it until taken
	task automatic send_value(input data_t v);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 10 : 0;
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		value    <= v;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Draw a number: full 32-bit noise, a random digit count, or near a power of ten
	function automatic data_t random_number();
		longint lo;
		longint hi;
		longint mag;
		int     n;
		logic   neg;
		neg = 1'($urandom_range(1));
		case ($urandom_range(9))
			0, 1, 2: begin
				return data_t'($urandom);
			end
			3, 4: begin
				n = $urandom_range(1, 10);
				lo = 1;
				repeat (n) lo = lo * 10;
				mag = lo + $urandom_range(2) - 1;
				if (mag > 64'd2147483648) mag = 64'd2147483648 - $urandom_range(1);
			end
			default: begin
				n = $urandom_range(1, 10);
				lo = 1;
				repeat (n - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (n == 1) lo = 0;
				if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
				mag = lo + (longint'($urandom) % (hi - lo + 1));
			end
		endcase
		if (mag > 64'd2147483647) neg = 1'b1;
		return neg ? data_t'(-mag) : data_t'(mag);
	endfunction

	initial begin
		int k;
		in_valid  = 1'b0;
		value     = '0;
		arst_n    = 1'b0;
		idle_mode = IDLE_NONE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_values[i]) begin
			send_value(corner_values[i]);
		end

		// Random part, split over the idling phases
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			idle_mode <= idle_mode_t'(k / (RANDOM_ITEMS / 4));
			send_value(random_number());
		end
		in_valid  <= 1'b0;
		idle_mode <= IDLE_NONE;

		// Drain the remaining characters
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
